// ----- hdl/ptc_pkg.sv -----
// Shared types, register indexes, state encoding and arithmetic helpers
// for the pressure/temperature compensation block. No dependencies.
package ptc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OSS     = 3'd5;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure_bytes;
  } ptc_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [31:0] pressure_pascal;
    logic               divide_error;
  } ptc_out_t;

  // queued work: raw temperature and pressure already aligned to oss
  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] up;
  } ptc_job_t;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } ptc_cal_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_X1, ST_DEN, ST_SDIV, ST_B5, ST_B6SQ, ST_M1, ST_M2, ST_M3, ST_M4,
    ST_SUMS, ST_B4, ST_B7, ST_UDIV, ST_PQ, ST_PSQ, ST_PM1, ST_PM2, ST_PFIN, ST_ERR
  } ptc_state_t;

  // low 32 bits of a signed 32x32 product
  function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  // signed divide by 2^n, truncating toward zero
  function automatic logic signed [31:0] div_pow2(input logic signed [31:0] x,
                                                  input int n);
    logic signed [31:0] bias;
    logic signed [31:0] s;
    bias = x[31] ? ((32'sd1 <<< n) - 32'sd1) : 32'sd0;
    s    = x + bias;
    return s >>> n;
  endfunction

endpackage

// ----- hdl/ptc_front.sv -----
// Front end: takes items, aligns the raw pressure to the oversampling
// setting and queues them for the back end. Depends on ptc_pkg.
module ptc_front #(
  parameter int DEPTH = ptc_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ptc_pkg::ptc_in_t  item,
  input  logic [1:0]        oss,
  output logic              full,
  output logic              job_valid,
  output ptc_pkg::ptc_job_t job,
  input  logic              pop
);
  import ptc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ptc_job_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [3:0]      shamt;
  ptc_job_t        new_job;
  logic            push;
  logic            do_pop;

  assign shamt     = 4'd8 - {2'b00, oss};
  assign new_job   = '{ut: item.raw_temperature, up: item.raw_pressure_bytes >> shamt};
  assign full      = (count == CW'(DEPTH));
  assign job_valid = (count != '0);
  assign job       = mem[rd_ptr];
  assign push      = accept;
  assign do_pop    = pop && job_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= new_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/ptc_back.sv -----
// Back end: sequencer running the integer compensation on one queued job,
// with a shared bit-serial divider. Depends on ptc_pkg.
module ptc_back (
  input  logic              clk,
  input  logic              rst,
  input  ptc_pkg::ptc_cal_t cal,
  input  logic              job_valid,
  input  ptc_pkg::ptc_job_t job,
  output logic              pop,
  output logic              done,
  output ptc_pkg::ptc_out_t result
);
  import ptc_pkg::*;

  ptc_state_t state, state_next;

  ptc_job_t           cur;
  logic signed [31:0] x1, t, b6, sq, xa, xb, xc, xd, b3, x3s, p;
  logic [31:0]        b4;
  logic               neg, dbl;
  logic [32:0]        rem;
  logic [31:0]        dq, dd;
  logic [4:0]         cnt;
  logic               emit_ok, emit_err;

  // calibration fields
  logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = 32'(signed'(cal.ac1_ac2[31:16]));
  assign ac2 = 32'(signed'(cal.ac1_ac2[15:0]));
  assign ac3 = 32'(signed'(cal.ac3_ac4[31:16]));
  assign ac4 = cal.ac3_ac4[15:0];
  assign ac5 = cal.ac5_ac6[31:16];
  assign ac6 = cal.ac5_ac6[15:0];
  assign b1  = 32'(signed'(cal.b1_b2[31:16]));
  assign b2  = 32'(signed'(cal.b1_b2[15:0]));
  assign mc  = 32'(signed'(cal.mc_md[31:16]));
  assign md  = 32'(signed'(cal.mc_md[15:0]));

  // datapath terms
  logic signed [16:0] tdiff;
  logic signed [33:0] tprod;
  logic signed [31:0] den, num, quo, b5, b3a, b3s, x3, pd, pf, tsat_src;
  logic [32:0]        rem_sh;
  logic               ge;
  logic [47:0]        b4prod;
  logic [31:0]        pdiff, b7, b7prod_lo;
  logic [47:0]        b7prod;
  logic [15:0]        ratio;
  logic signed [15:0] tsat;

  assign tdiff  = $signed({1'b0, cur.ut}) - $signed({1'b0, ac6});
  assign tprod  = tdiff * $signed({1'b0, ac5});
  assign den    = x1 + md;
  assign num    = {mc[20:0], 11'b0};
  assign rem_sh = {rem[31:0], dq[31]};
  assign ge     = (rem_sh >= {1'b0, dd});
  assign quo    = neg ? -$signed(dq) : $signed(dq);
  assign b5     = x1 + quo;
  assign b3a    = (ac1 <<< 2) + xa + xb;
  assign b3s    = b3a << cal.oss;
  assign x3     = div_pow2(xc + xd + 32'sd2, 2);
  assign b4prod = {16'b0, ac4} * {16'b0, x3s};
  assign pdiff  = {8'b0, cur.up} - b3;
  assign ratio  = 16'(32'd50000 >> cal.oss);
  assign b7prod = {16'b0, pdiff} * {32'b0, ratio};
  assign b7prod_lo = b7prod[31:0];
  assign b7     = b7prod_lo;
  assign pd     = div_pow2(p, 8);
  assign pf     = p + div_pow2(xa + xb + 32'sd3791, 4);
  assign tsat_src = t;

  always_comb begin
    if (tsat_src > 32'sd32767) begin
      tsat = 16'sh7fff;
    end else if (tsat_src < -32'sd32768) begin
      tsat = 16'sh8000;
    end else begin
      tsat = tsat_src[15:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (job_valid) state_next = ST_X1;
      ST_X1:   state_next = ST_DEN;
      ST_DEN:  state_next = (den == '0) ? ST_ERR : ST_SDIV;
      ST_SDIV: if (cnt == 5'd31) state_next = ST_B5;
      ST_B5:   state_next = ST_B6SQ;
      ST_B6SQ: state_next = ST_M1;
      ST_M1:   state_next = ST_M2;
      ST_M2:   state_next = ST_M3;
      ST_M3:   state_next = ST_M4;
      ST_M4:   state_next = ST_SUMS;
      ST_SUMS: state_next = ST_B4;
      ST_B4:   state_next = ST_B7;
      ST_B7:   state_next = (b4 == '0) ? ST_ERR : ST_UDIV;
      ST_UDIV: if (cnt == 5'd31) state_next = ST_PQ;
      ST_PQ:   state_next = ST_PSQ;
      ST_PSQ:  state_next = ST_PM1;
      ST_PM1:  state_next = ST_PM2;
      ST_PM2:  state_next = ST_PFIN;
      ST_PFIN: state_next = ST_IDLE;
      ST_ERR:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = 1'b0;
    emit_ok  = 1'b0;
    emit_err = 1'b0;
    case (state)
      ST_IDLE: pop = job_valid;
      ST_PFIN: emit_ok = 1'b1;
      ST_ERR:  emit_err = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= emit_ok || emit_err;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (job_valid) cur <= job;
      ST_X1:   x1 <= div_pow2(tprod[31:0], 15);
      ST_DEN: begin
        neg <= num[31] ^ den[31];
        dq  <= num[31] ? 32'(-num) : num;
        dd  <= den[31] ? 32'(-den) : den;
        rem <= '0;
        cnt <= '0;
      end
      ST_SDIV, ST_UDIV: begin
        rem <= ge ? rem_sh - {1'b0, dd} : rem_sh;
        dq  <= {dq[30:0], ge};
        cnt <= cnt + 1'b1;
      end
      ST_B5: begin
        t  <= div_pow2(b5 + 32'sd8, 4);
        b6 <= b5 - 32'sd4000;
      end
      ST_B6SQ: sq <= div_pow2(mul32(b6, b6), 12);
      ST_M1:   xa <= div_pow2(mul32(b2, sq), 11);
      ST_M2:   xb <= div_pow2(mul32(ac2, b6), 11);
      ST_M3:   xc <= div_pow2(mul32(ac3, b6), 13);
      ST_M4:   xd <= div_pow2(mul32(b1, sq), 16);
      ST_SUMS: begin
        b3  <= div_pow2(b3s + 32'sd2, 2);
        x3s <= x3 + 32'sd32768;
      end
      ST_B4:   b4 <= {15'b0, b4prod[31:15]};
      ST_B7: begin
        // a dividend with its top bit set is divided as is and the quotient doubled
        dbl <= b7[31];
        dq  <= b7[31] ? b7 : {b7[30:0], 1'b0};
        dd  <= b4;
        rem <= '0;
        cnt <= '0;
      end
      ST_PQ:   p  <= dbl ? {dq[30:0], 1'b0} : dq;
      ST_PSQ:  xa <= mul32(pd, pd);
      ST_PM1:  xa <= div_pow2(mul32(xa, 32'sd3038), 16);
      ST_PM2:  xb <= div_pow2(mul32(-32'sd7357, p), 16);
      default: ;
    endcase
    if (emit_ok) begin
      result <= '{temperature_tenths: tsat, pressure_pascal: pf, divide_error: 1'b0};
    end else if (emit_err) begin
      result <= '{temperature_tenths: '0, pressure_pascal: '0, divide_error: 1'b1};
    end
  end

endmodule

// ----- hdl/pressure_temperature_compensation.sv -----
// The back-end sequencer handles one item at a time and runs two 32-step
// bit-serial divisions per item, stopping early on a zero divisor; a 4-deep
// queue takes items while one is in progress, busy is high while it is full.
// done pulses for one cycle with the result. Synchronous reset empties the
// queue, idles the sequencer and clears calibration to zero.
module pressure_temperature_compensation #(
  parameter int DEPTH = ptc_pkg::FIFO_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  ptc_pkg::ptc_in_t               item,
  output logic                           done,
  output ptc_pkg::ptc_out_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import ptc_pkg::*;

  ptc_cal_t cal;
  logic     full, job_valid, pop;
  ptc_job_t job;

  assign cfg_ready = 1'b1;
  assign busy      = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AC1_AC2: cal.ac1_ac2 <= cfg_data;
        REG_AC3_AC4: cal.ac3_ac4 <= cfg_data;
        REG_AC5_AC6: cal.ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal.b1_b2   <= cfg_data;
        REG_MC_MD:   cal.mc_md   <= cfg_data;
        REG_OSS:     cal.oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  ptc_front #(.DEPTH(DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (start && !full),
    .item      (item),
    .oss       (cal.oss),
    .full      (full),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop)
  );

  ptc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .done      (done),
    .result    (result)
  );

endmodule

// ----- hdl/ptc_checker.sv -----
// Port-level checks for the compensation block, bound to the top level.
// Depends on ptc_pkg.
module ptc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input ptc_pkg::ptc_out_t result
);
  import ptc_pkg::*;

  // the sequencer never finishes two jobs in adjacent cycles
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done on consecutive cycles");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.divide_error |->
      result.temperature_tenths == 16'sd0 && result.pressure_pascal == 32'sd0)
    else $error("divide error with non-zero result");

  // the queue only fills on a transfer
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  a_rst_done: assert property (@(posedge clk) disable iff (rst) $past(rst) |-> !done)
    else $error("done straight after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
